// ===== rtl/sip_option_tag_flag_parser_defines.svh =====
// assertion macros shared by the option tag parser
`ifndef SIP_OPTION_TAG_FLAG_PARSER_DEFINES_SVH
`define SIP_OPTION_TAG_FLAG_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SOTFP_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SOTFP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sotfp_pkg.sv =====
// constants and match functions for the sip option tag parser
package sotfp_pkg;

    localparam int unsigned TAG_COUNT   = 5;
    localparam int unsigned TAG_MAX_LEN = 9;
    localparam int unsigned POS_W       = 4;

    localparam logic [TAG_COUNT-1:0] ALL_TAGS = '1;

    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] DELIM_SPACE = 8'h20;
    localparam logic [7:0] DELIM_TAB   = 8'h09;
    localparam logic [7:0] DELIM_CR    = 8'h0d;
    localparam logic [7:0] DELIM_LF    = 8'h0a;
    localparam logic [7:0] DELIM_COMMA = 8'h2c;

    typedef logic [TAG_COUNT-1:0] tag_mask_t;
    typedef logic [POS_W-1:0]     tag_pos_t;

    function automatic logic is_token_break(input logic [7:0] c);
        return (c == DELIM_SPACE) || (c == DELIM_TAB) || (c == DELIM_CR) ||
               (c == DELIM_LF) || (c == DELIM_COMMA);
    endfunction

    // tags whose character at pos equals the folded byte
    // bit order: eventlist, timer, 100rel, gruu, path
    function automatic tag_mask_t tag_char_hit(input tag_pos_t pos, input logic [7:0] low);
        tag_mask_t hit;
        hit = '0;
        unique case (pos)
            4'd0: hit = {low == "e", low == "t", low == "1", low == "g", low == "p"};
            4'd1: hit = {low == "v", low == "i", low == "0", low == "r", low == "a"};
            4'd2: hit = {low == "e", low == "m", low == "0", low == "u", low == "t"};
            4'd3: hit = {low == "n", low == "e", low == "r", low == "u", low == "h"};
            4'd4: hit = {low == "t", low == "r", low == "e", 1'b0, 1'b0};
            4'd5: hit = {low == "l", 1'b0, low == "l", 1'b0, 1'b0};
            4'd6: hit = {low == "i", 4'b0000};
            4'd7: hit = {low == "s", 4'b0000};
            4'd8: hit = {low == "t", 4'b0000};
            default: hit = '0;
        endcase
        return hit;
    endfunction

    // tags whose full length equals pos
    function automatic tag_mask_t tag_len_hit(input tag_pos_t pos);
        tag_mask_t hit;
        hit = '0;
        unique case (pos)
            4'd4: hit = 5'b00011;
            4'd5: hit = 5'b01000;
            4'd6: hit = 5'b00100;
            4'd9: hit = 5'b10000;
            default: hit = '0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/sip_option_tag_flag_parser.sv =====
// sip supported header option tag parser, top level
//
//  channel | direction | fields                                       | handshake
//  --------+-----------+----------------------------------------------+-------------------
//  in      | to block  | data_byte, last_of_header, last_of_message   | in_valid / in_stall
//  out     | from block| header_flags, message_flags, message_done    | out_valid / out_stall
//
// one word per cycle sustained unless a header-end word meets a stalled result; each word
// is held in the input register, and a header result is then loaded into the result register
// the only work between registers is the per-byte tag compare and state update
// reset clears token state, flag accumulators and both valid bits
// a stalled result holds the input register only for a header-end word
module sip_option_tag_flag_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_of_header,
    input  logic       last_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] header_flags,
    output logic [4:0] message_flags,
    output logic       message_done
);

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_hdr_reg;
    logic       s1_msg_reg;

    // token and flag state
    sotfp_pkg::tag_pos_t  pos_reg, pos_next;
    sotfp_pkg::tag_mask_t cand_reg, cand_next;
    logic                 skip_reg, skip_next;
    sotfp_pkg::tag_mask_t hacc_reg, hacc_next;
    sotfp_pkg::tag_mask_t macc_reg, macc_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    sotfp_pkg::tag_mask_t hdr_flags_reg, hdr_flags_next;
    sotfp_pkg::tag_mask_t msg_flags_reg, msg_flags_next;
    logic                 msg_done_reg;

    logic out_free;
    logic s1_fire;
    logic res_load;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!s1_hdr_reg || out_free);
    assign res_load = s1_fire && s1_hdr_reg;
    assign in_stall = s1_valid_reg && !s1_fire;

    assign s1_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_hdr_reg  <= last_of_header;
            s1_msg_reg  <= last_of_message;
        end
    end

    // per-word update: token byte or delimiter, then header end closes again
    always_comb
    begin
        logic [7:0]           low;
        sotfp_pkg::tag_mask_t keep;
        sotfp_pkg::tag_mask_t hit1;
        sotfp_pkg::tag_mask_t hit2;
        sotfp_pkg::tag_pos_t  pos1;
        sotfp_pkg::tag_mask_t cand1;
        logic                 skip1;
        sotfp_pkg::tag_mask_t hacc1;
        sotfp_pkg::tag_mask_t hdr_all;

        low   = s1_byte_reg | sotfp_pkg::CASE_BIT;
        keep  = cand_reg & sotfp_pkg::tag_char_hit(pos_reg, low);
        hit1  = '0;
        pos1  = pos_reg;
        cand1 = cand_reg;
        skip1 = skip_reg;
        hacc1 = hacc_reg;

        if (sotfp_pkg::is_token_break(s1_byte_reg))
        begin
            if (!skip_reg && (pos_reg != '0))
            begin
                hit1 = cand_reg & sotfp_pkg::tag_len_hit(pos_reg);
            end
            hacc1 = hacc_reg | hit1;
            pos1  = '0;
            cand1 = sotfp_pkg::ALL_TAGS;
            skip1 = 1'b0;
        end
        else if (!skip_reg)
        begin
            cand1 = keep;
            if (keep == '0)
            begin
                skip1 = 1'b1;
            end
            else
            begin
                pos1 = pos_reg + sotfp_pkg::tag_pos_t'(1);
            end
        end

        // header end counts as a delimiter
        hit2 = '0;
        if (!skip1 && (pos1 != '0))
        begin
            hit2 = cand1 & sotfp_pkg::tag_len_hit(pos1);
        end
        hdr_all = hacc1 | hit2;

        hdr_flags_next = hdr_all;
        msg_flags_next = macc_reg | hdr_all;

        pos_next  = pos_reg;
        cand_next = cand_reg;
        skip_next = skip_reg;
        hacc_next = hacc_reg;
        macc_next = macc_reg;
        if (s1_fire)
        begin
            if (s1_hdr_reg)
            begin
                pos_next  = '0;
                cand_next = sotfp_pkg::ALL_TAGS;
                skip_next = 1'b0;
                hacc_next = '0;
                macc_next = s1_msg_reg ? '0 : msg_flags_next;
            end
            else
            begin
                pos_next  = pos1;
                cand_next = cand1;
                skip_next = skip1;
                hacc_next = hacc1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cand_reg <= sotfp_pkg::ALL_TAGS;
            skip_reg <= 1'b0;
            hacc_reg <= '0;
            macc_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            cand_reg <= cand_next;
            skip_reg <= skip_next;
            hacc_reg <= hacc_next;
            macc_reg <= macc_next;
        end
    end

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            hdr_flags_reg <= hdr_flags_next;
            msg_flags_reg <= msg_flags_next;
            msg_done_reg  <= s1_msg_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign header_flags  = hdr_flags_reg;
    assign message_flags = msg_flags_reg;
    assign message_done  = msg_done_reg;

`include "sip_option_tag_flag_parser_defines.svh"

    `SOTFP_ASSERT_NOW(a_msg_covers_hdr, clk, rst_n, out_valid_reg,
        (hdr_flags_reg & ~msg_flags_reg) == '0, "message flags miss a header flag")

    `SOTFP_ASSERT_NOW(a_skip_no_cand, clk, rst_n, skip_reg,
        (cand_reg == '0) && (pos_reg <= sotfp_pkg::tag_pos_t'(sotfp_pkg::TAG_MAX_LEN)),
        "skipped token still has candidates or position overran")

    `SOTFP_ASSERT_NEXT(a_msg_end_clear, clk, rst_n, res_load && s1_msg_reg,
        (macc_reg == '0) && (hacc_reg == '0), "flags not cleared after message end")

    `SOTFP_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall,
        s1_valid_reg && s1_hdr_reg && out_valid_reg, "input stalled without cause")

endmodule
